[design/cpfsk_pkg.sv]
// Shared constants, configuration indexes and the cosine table builder for the CPFSK modulator.
`default_nettype none

package cpfsk_pkg;

    // Widths fixed by the configuration register list and the result fields
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int SPB_W       = 16;
    localparam int AMP_W       = 15;
    localparam int COS_W       = 16;
    localparam int WAVE_W      = 16;
    localparam int PROD_W      = AMP_W + 1 + COS_W;
    localparam int FRAC_BITS   = 15;

    // Saturation width of the sample datapath
    localparam int SAMPLE_BITS = 16;

    // Defaults of the structural parameters
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_STEP    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_STEP     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_PER_BIT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE       = 2'd3;

    localparam logic [SPB_W-1:0] SPB_RESET = SPB_W'(100);

    // Output clamp: the tighter of the sample range and the 16-bit field
    localparam longint SAMPLE_MAX_L = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SAMPLE_MIN_L = -SAMPLE_MAX_L - 64'sd1;
    localparam longint WAVE_MAX_L   = (SAMPLE_MAX_L < 64'sd32767) ? SAMPLE_MAX_L : 64'sd32767;
    localparam longint WAVE_MIN_L   = (SAMPLE_MIN_L > -64'sd32768) ? SAMPLE_MIN_L : -64'sd32768;
    localparam logic signed [WAVE_W:0] WAVE_MAX = (WAVE_W + 1)'(WAVE_MAX_L);
    localparam logic signed [WAVE_W:0] WAVE_MIN = (WAVE_W + 1)'(WAVE_MIN_L);

    localparam longint Q30_ONE     = 64'sd1 <<< 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef logic signed [COS_W-1:0]  t_cos;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [WAVE_W-1:0] t_wave;

    // Q1.15 cosine of table entry k; evaluated at elaboration only.
    // Degree-14 Taylor series in Q30 with truncating division, then quadrant folding.
    function automatic t_cos cos_entry(input int unsigned k, input int unsigned abits);
        longint quarter;
        longint quad;
        longint r;
        longint rq;
        longint theta;
        longint x2;
        longint t;
        longint q;
        logic   neg;
        quarter = 64'sd1 <<< (abits - 2);
        quad    = (longint'(k) >>> (abits - 2)) & 64'sd3;
        r       = longint'(k) & (quarter - 64'sd1);
        rq      = ((quad == 64'sd1) || (quad == 64'sd3)) ? (quarter - r) : r;
        neg     = (quad == 64'sd1) || (quad == 64'sd2);
        theta   = (rq * HALF_PI_Q30) >>> (abits - 2);
        x2      = (theta * theta) / Q30_ONE;
        t       = Q30_ONE;
        t       = Q30_ONE - ((x2 * t) / 182) / Q30_ONE;
        t       = Q30_ONE - ((x2 * t) / 132) / Q30_ONE;
        t       = Q30_ONE - ((x2 * t) / 90) / Q30_ONE;
        t       = Q30_ONE - ((x2 * t) / 56) / Q30_ONE;
        t       = Q30_ONE - ((x2 * t) / 30) / Q30_ONE;
        t       = Q30_ONE - ((x2 * t) / 12) / Q30_ONE;
        t       = Q30_ONE - ((x2 * t) / 2) / Q30_ONE;
        q       = (t + 64'sd16384) / 64'sd32768;
        if (q < 0) begin
            q = 0;
        end
        if (q > 64'sd32767) begin
            q = 64'sd32767;
        end
        return neg ? COS_W'(-q) : COS_W'(q);
    endfunction

endpackage

`default_nettype wire

[design/continuous_phase_fsk_modulator_core.sv]
// Top level of the continuous-phase FSK modulator: phase accumulator, cosine ROM, scaler.
//
// Usage: one input transaction (i_valid/o_ready, field i_data_bit) per output sample.
// Each input transaction yields exactly one output transaction (o_valid/i_ready) with
// o_wave_sample = amplitude * cos(phase) >> 15, saturated, and o_bit_start marking the
// first sample of a bit period; the data bit is latched only on that first sample.
// From input acceptance to o_valid a sample passes the cosine ROM read, the multiply,
// then the shift and saturate into the output register. Throughput is one sample per
// cycle while the receiver does not stall; the phase accumulator updates in the cycle
// of acceptance, so the cosine ROM read port and the single phase adder set that rate.
// When the receiver stalls, each stage holds while the one after it is full, so up to
// three samples sit in flight; a new input is still accepted while any stage is empty.
// Configuration writes (i_cfg_valid/o_cfg_ready, index and data) are always accepted
// and take effect on the next input; write them only while no sample is in flight.
// Synchronous active-low reset clears the phase, the bit counter, the held bit and all
// pipeline valids, and loads register defaults (samples_per_bit 100, others zero).
// The cosine ROM is a constant table and needs no fill after reset.
`default_nettype none

module continuous_phase_fsk_modulator_core
    import cpfsk_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_data_bit,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic signed [WAVE_W-1:0]    o_wave_sample,
    output logic                        o_bit_start,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int TABLE_DEPTH = 1 << TABLE_ADDR_BITS;

    // Configuration registers
    logic [STEP_W-1:0] r_carrier_step;
    logic [STEP_W-1:0] r_offset_step;
    logic [SPB_W-1:0]  r_samples_per_bit;
    logic [AMP_W-1:0]  r_amplitude;

    // Modulator state
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [SPB_W-1:0]      r_sample_cnt;
    logic [SPB_W-1:0]      n_sample_cnt;
    logic                  r_held_bit;
    logic                  n_held_bit;

    // Pipeline
    logic                  r_v1, r_v2, r_v3;
    logic                  r_start1, r_start2;
    t_cos                  r_cos1;
    t_prod                 r_prod2;
    logic                  en1, en2, en3;
    logic                  in_accept;
    logic                  start;
    logic [PHASE_BITS-1:0] carrier_ext;
    logic [PHASE_BITS-1:0] offset_ext;
    logic [SPB_W-1:0]      period;
    logic [SPB_W:0]        cnt_inc;
    logic [TABLE_ADDR_BITS-1:0] rom_addr;
    logic signed [PROD_W-FRAC_BITS-1:0] scaled;
    logic signed [WAVE_W:0]             scaled_ext;
    t_wave                 n_wave;

    t_cos w_cos_rom [TABLE_DEPTH];

    // Constant cosine ROM, one entry per top-bits phase code
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
        assign w_cos_rom[g] = cos_entry(g, TABLE_ADDR_BITS);
    end

    // Each stage advances when the next one is empty or moving
    assign en3       = !r_v3 || i_ready;
    assign en2       = !r_v2 || en3;
    assign en1       = !r_v1 || en2;
    assign o_ready   = en1;
    assign in_accept = i_valid && en1;
    assign o_valid   = r_v3;
    assign o_cfg_ready = 1'b1;

    assign carrier_ext = PHASE_BITS'({{PHASE_BITS{1'b0}}, r_carrier_step});
    assign offset_ext  = PHASE_BITS'({{PHASE_BITS{1'b0}}, r_offset_step});
    assign rom_addr    = r_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];

    always_comb begin
        start      = (r_sample_cnt == '0);
        period     = (r_samples_per_bit == '0) ? SPB_W'(1) : r_samples_per_bit;
        n_held_bit = start ? i_data_bit : r_held_bit;
        n_phase    = r_phase + carrier_ext + (n_held_bit ? offset_ext : '0);
        cnt_inc    = {1'b0, r_sample_cnt} + (SPB_W + 1)'(1);
        // wrap also when the period was shortened below the counter
        n_sample_cnt = (cnt_inc >= {1'b0, period}) ? '0 : cnt_inc[SPB_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_step    <= '0;
            r_offset_step     <= '0;
            r_samples_per_bit <= SPB_RESET;
            r_amplitude       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CARRIER_STEP:    r_carrier_step    <= i_cfg_data[STEP_W-1:0];
                CFG_OFFSET_STEP:     r_offset_step     <= i_cfg_data[STEP_W-1:0];
                CFG_SAMPLES_PER_BIT: r_samples_per_bit <= i_cfg_data[SPB_W-1:0];
                CFG_AMPLITUDE:       r_amplitude       <= i_cfg_data[AMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_sample_cnt <= '0;
            r_held_bit   <= 1'b0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_sample_cnt <= n_sample_cnt;
            r_held_bit   <= n_held_bit;
        end
    end

    // Stage 1: ROM read with registered output
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_cos1   <= w_cos_rom[rom_addr];
            r_start1 <= start;
        end
    end

    // Stage 2: scale by amplitude
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_prod2  <= t_prod'($signed({1'b0, r_amplitude})) * t_prod'(r_cos1);
            r_start2 <= r_start1;
        end
    end

    // Stage 3: floor shift and saturate
    always_comb begin
        scaled     = r_prod2[PROD_W-1:FRAC_BITS];
        scaled_ext = (WAVE_W + 1)'(scaled);
        if (scaled_ext > WAVE_MAX) begin
            n_wave = WAVE_MAX[WAVE_W-1:0];
        end else if (scaled_ext < WAVE_MIN) begin
            n_wave = WAVE_MIN[WAVE_W-1:0];
        end else begin
            n_wave = scaled_ext[WAVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            o_wave_sample <= n_wave;
            o_bit_start   <= r_start2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= in_accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

endmodule

`default_nettype wire

[design/cpfsk_checker.sv]
// Port-level assertions for the CPFSK modulator and their bind to the top level.
`default_nettype none

module cpfsk_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_wave_sample,
    input wire logic        o_bit_start
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_wave_sample) && $stable(o_bit_start))
        else $error("output transaction dropped or changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // An empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with an empty output register");

    // An accepted sample reaches the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##3 o_valid)
        else $error("accepted transaction did not reach the output");

endmodule

bind continuous_phase_fsk_modulator_core cpfsk_checker u_cpfsk_checker (.*);

`default_nettype wire
